// ===== src/hlp_pkg.sv =====
`timescale 1ns / 1ps

package hlp_pkg;

    // Result kinds
    localparam logic [1:0] KIND_NAME    = 2'd0;
    localparam logic [1:0] KIND_VALID   = 2'd1;
    localparam logic [1:0] KIND_INVALID = 2'd2;
    localparam logic [1:0] KIND_ENDED   = 2'd3;

    // Characters of interest
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CASE_GAP = 8'h20;

    localparam logic [7:0] OCTET_MAX = 8'd255;
    localparam logic [1:0] DOTS_FULL = 2'd3;

    // Result queue depth
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef enum logic [3:0] {
        PH_START = 4'b0001,
        PH_ADDR  = 4'b0010,
        PH_NAME  = 4'b0100,
        PH_SKIP  = 4'b1000
    } hlp_phase_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } hlp_char_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  name_byte;
        logic [31:0] ip_address;
        logic        text_done;
        logic        run_last;
    } hlp_result_t;

    typedef struct packed {
        hlp_phase_t  phase;
        logic [7:0]  octet_value;
        logic        octet_too_big;
        logic        octet_has_digit;
        logic [1:0]  dots_seen;
        logic [23:0] upper_octets;
        logic        label_empty;
        logic        name_bad;
    } hlp_state_t;

    // Line state after a line closes or before a new one opens
    function automatic hlp_state_t hlp_clear_line(input hlp_phase_t ph);
        hlp_state_t s;
        s.phase           = ph;
        s.octet_value     = 8'd0;
        s.octet_too_big   = 1'b0;
        s.octet_has_digit = 1'b0;
        s.dots_seen       = 2'd0;
        s.upper_octets    = 24'd0;
        s.label_empty     = 1'b1;
        s.name_bad        = 1'b0;
        return s;
    endfunction

endpackage

// ===== src/hlp_line_step.sv =====
`timescale 1ns / 1ps

module hlp_line_step (
    input  hlp_pkg::hlp_state_t  state,
    input  hlp_pkg::hlp_char_t   char_in,
    output hlp_pkg::hlp_state_t  state_next,
    output hlp_pkg::hlp_result_t res0,
    output hlp_pkg::hlp_result_t res1,
    output logic [1:0]           res_count
);
    import hlp_pkg::*;

    // Advance the address parse by one byte
    function automatic hlp_state_t addr_byte(input hlp_state_t s, input logic [7:0] b);
        hlp_state_t  r;
        logic [11:0] v;
        r = s;
        v = ({4'd0, s.octet_value} << 3) + ({4'd0, s.octet_value} << 1)
            + {4'd0, b - CH_ZERO};
        if (b >= CH_ZERO && b <= CH_NINE)
        begin
            if (v > {4'd0, OCTET_MAX})
            begin
                r.octet_too_big = 1'b1;
                r.octet_value   = OCTET_MAX;
            end
            else
            begin
                r.octet_value = v[7:0];
            end
            r.octet_has_digit = 1'b1;
        end
        else if (b == CH_DOT)
        begin
            if (!s.octet_has_digit || s.octet_too_big || s.dots_seen == DOTS_FULL)
            begin
                r.phase = PH_SKIP;
            end
            else
            begin
                r.upper_octets    = {s.upper_octets[15:0], s.octet_value};
                r.dots_seen       = s.dots_seen + 2'd1;
                r.octet_value     = 8'd0;
                r.octet_has_digit = 1'b0;
            end
        end
        else if (b == CH_SPACE)
        begin
            if (!s.octet_has_digit || s.octet_too_big || s.dots_seen != DOTS_FULL)
            begin
                r.phase = PH_SKIP;
            end
            else
            begin
                r.phase           = PH_NAME;
                r.octet_has_digit = 1'b0;
                r.label_empty     = 1'b1;
                r.name_bad        = 1'b0;
            end
        end
        else
        begin
            r.phase = PH_SKIP;
        end
        return r;
    endfunction

    logic        eol;
    logic        eot;
    logic        close_line;
    logic        name_emit;
    logic        rec_emit;
    logic        rec_ok;
    logic [7:0]  name_char;
    hlp_state_t  st_mid;
    hlp_state_t  st_start;
    hlp_result_t name_res;
    hlp_result_t rec_res;

    assign eol      = (char_in.text_byte == CH_LF) || (char_in.text_byte == CH_CR);
    assign eot      = char_in.end_of_text;
    assign st_start = hlp_clear_line(PH_ADDR);

    // Per-phase byte handling
    always_comb
    begin
        st_mid     = state;
        close_line = 1'b0;
        name_emit  = 1'b0;
        name_char  = char_in.text_byte;
        unique case (state.phase)
            PH_START:
            begin
                if (!eol)
                begin
                    st_mid = addr_byte(st_start, char_in.text_byte);
                end
            end
            PH_ADDR:
            begin
                if (eol)
                    close_line = 1'b1;
                else
                    st_mid = addr_byte(state, char_in.text_byte);
            end
            PH_NAME:
            begin
                if (eol)
                begin
                    close_line = 1'b1;
                end
                else
                begin
                    if (char_in.text_byte == CH_DOT)
                    begin
                        if (state.label_empty)
                            st_mid.name_bad = 1'b1;
                        st_mid.label_empty = 1'b1;
                    end
                    else
                    begin
                        if (char_in.text_byte >= CH_UP_A && char_in.text_byte <= CH_UP_Z)
                            name_char = char_in.text_byte + CASE_GAP;
                        st_mid.label_empty = 1'b0;
                    end
                    st_mid.octet_has_digit = 1'b1;
                    name_emit              = 1'b1;
                end
            end
            PH_SKIP:
            begin
                if (eol)
                    close_line = 1'b1;
            end
            default:
            begin
                st_mid = state;
            end
        endcase
        if (eot && st_mid.phase != PH_START)
            close_line = 1'b1;
    end

    // Record status at line close
    assign rec_ok = (st_mid.phase == PH_NAME) && !st_mid.name_bad
                    && !(st_mid.label_empty && st_mid.octet_has_digit);

    assign rec_emit = close_line || eot;

    always_comb
    begin
        name_res            = '0;
        name_res.kind       = KIND_NAME;
        name_res.name_byte  = name_char;
        name_res.run_last   = !rec_emit;

        rec_res             = '0;
        rec_res.run_last    = 1'b1;
        rec_res.text_done   = eot;
        if (close_line)
        begin
            if (rec_ok)
            begin
                rec_res.kind       = KIND_VALID;
                rec_res.ip_address = {st_mid.upper_octets, st_mid.octet_value};
            end
            else
            begin
                rec_res.kind = KIND_INVALID;
            end
        end
        else
        begin
            rec_res.kind = KIND_ENDED;
        end
    end

    // Pack results in order, name byte first
    always_comb
    begin
        res0      = name_emit ? name_res : rec_res;
        res1      = rec_res;
        res_count = {1'b0, name_emit} + {1'b0, rec_emit};
        if (rec_emit)
            state_next = hlp_clear_line(PH_START);
        else
            state_next = st_mid;
    end

endmodule

// ===== src/hlp_result_fifo.sv =====
`timescale 1ns / 1ps

module hlp_result_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [1:0]           push_count,
    input  hlp_pkg::hlp_result_t push0,
    input  hlp_pkg::hlp_result_t push1,
    output logic                 room_for_two,
    output logic                 result_valid,
    input  logic                 result_ready,
    output hlp_pkg::hlp_result_t result_word
);
    import hlp_pkg::*;

    hlp_result_t          mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_next;
    logic [FIFO_AW:0]     count_reg;
    logic [FIFO_AW:0]     count_next;
    logic                 pop;

    assign pop          = result_valid && result_ready;
    assign result_valid = (count_reg != '0);
    assign result_word  = mem[rd_ptr_reg];
    assign room_for_two = (count_reg <= (FIFO_AW+1)'(FIFO_DEPTH - 2));

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FIFO_AW'(push_count);
        rd_ptr_next = rd_ptr_reg + FIFO_AW'(pop);
        count_next  = count_reg + (FIFO_AW+1)'(push_count) - (FIFO_AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store up to two words per cycle
    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
            mem[wr_ptr_reg] <= push0;
        if (push_count == 2'd2)
            mem[wr_ptr_reg + FIFO_AW'(1)] <= push1;
    end

endmodule

// ===== src/hosts_line_parser_core.sv =====
`timescale 1ns / 1ps

// Hosts-text line parser. Takes one text byte per word on the char channel and
// parses each line as a dotted-quad IPv4 address, a space and a host name.
// Every name byte comes out at once, lowercased, as a name word; at each line
// end (CR or LF, or the end_of_text flag) a record word reports the line as
// valid with its address or as invalid. A buffer that ends between lines gives
// one text-ended word. run_last marks the last word caused by one input byte.
// Rate: one byte per clock sustained. A byte is registered, then parsed
// into up to two result words that enter a four-entry result queue; a byte
// is parsed only while at most two words wait there. The queue drains one
// word per clock, and with the output always ready it never holds more than
// two words: after a byte that raises two (a final name byte with end of text)
// the next such byte comes only after address bytes that raise none. So the
// input stalls only while the result side holds off.
// A byte's first result word is offered from the result queue, once the byte
// has passed the input register and been written into that queue.
module hosts_line_parser_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 char_valid,
    output logic                 char_ready,
    input  hlp_pkg::hlp_char_t   char_word,
    output logic                 result_valid,
    input  logic                 result_ready,
    output hlp_pkg::hlp_result_t result_word
);
    import hlp_pkg::*;

    hlp_char_t   char_reg;
    logic        char_valid_reg;
    logic        char_valid_next;
    hlp_state_t  state_reg;
    hlp_state_t  state_next;
    hlp_state_t  step_state;
    hlp_result_t res0;
    hlp_result_t res1;
    logic [1:0]  res_count;
    logic [1:0]  push_count;
    logic        room_for_two;
    logic        fire;

    // Parse the held byte once the queue can take both words
    assign fire       = char_valid_reg && room_for_two;
    assign char_ready = !char_valid_reg || fire;
    assign push_count = fire ? res_count : 2'd0;

    hlp_line_step u_step (
        .state      (state_reg),
        .char_in    (char_reg),
        .state_next (step_state),
        .res0       (res0),
        .res1       (res1),
        .res_count  (res_count)
    );

    hlp_result_fifo u_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .push_count   (push_count),
        .push0        (res0),
        .push1        (res1),
        .room_for_two (room_for_two),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_word  (result_word)
    );

    always_comb
    begin
        char_valid_next = (char_valid && char_ready) || (char_valid_reg && !fire);
        state_next      = fire ? step_state : state_reg;
    end

    // Hold parse state and input valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_valid_reg <= 1'b0;
            state_reg      <= hlp_clear_line(PH_START);
        end
        else
        begin
            char_valid_reg <= char_valid_next;
            state_reg      <= state_next;
        end
    end

    // Capture the incoming byte
    always_ff @(posedge clk)
    begin
        if (char_valid && char_ready)
            char_reg <= char_word;
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    import hlp_pkg::*;

    // Bytes used to build text lines, beyond those in the package
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_HYPHEN = 8'h2D;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_TICK   = 8'h60;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_HIGH   = 8'hFF;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 20;
    localparam int REPORT_LIMIT   = 10;
    localparam int BUSY_BYTES     = 570;
    localparam int TOTAL_BYTES    = 650;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        char_valid = 1'b0;
    logic        char_ready;
    hlp_char_t   char_word = '0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    hlp_result_t result_word;

    hosts_line_parser_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_ready   (char_ready),
        .char_word    (char_word),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_word  (result_word)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    hlp_char_t   text_to_send[$];
    hlp_result_t expected_parse_words[$];
    logic [7:0]  line_bytes[$];

    logic calm_tail = 1'b0;
    int   send_gap = 0;
    int   result_gap = 0;
    int   idle_count = 0;
    int   queued_bytes = 0;
    int   sent_bytes = 0;
    int   checked_words = 0;
    int   mismatch_count = 0;
    int   name_words = 0;
    int   good_records = 0;
    int   bad_records = 0;
    int   bare_ends = 0;

    // Parser state as the block should hold it
    hlp_phase_t  line_phase;
    logic [7:0]  octet_acc;
    logic        octet_over;
    logic        octet_seen;
    logic [1:0]  dot_count;
    logic [23:0] high_octets;
    logic        label_open_empty;
    logic        label_fault;

    task automatic clear_line_state();
        octet_acc        = 8'd0;
        octet_over       = 1'b0;
        octet_seen       = 1'b0;
        dot_count        = 2'd0;
        high_octets      = 24'd0;
        label_open_empty = 1'b1;
        label_fault      = 1'b0;
    endtask

    // Advance the address scan by one byte; any fault sends the line to skip
    task automatic feed_address(input logic [7:0] b);
        int v;
        if (b >= CH_ZERO && b <= CH_NINE)
        begin
            v = int'(octet_acc) * 10 + int'(b - CH_ZERO);
            if (v > 255)
            begin
                octet_over = 1'b1;
                v = 255;
            end
            octet_acc  = v[7:0];
            octet_seen = 1'b1;
        end
        else if (b == CH_DOT)
        begin
            if (!octet_seen || octet_over || dot_count == DOTS_FULL)
                line_phase = PH_SKIP;
            else
            begin
                high_octets = {high_octets[15:0], octet_acc};
                dot_count   = dot_count + 2'd1;
                octet_acc   = 8'd0;
                octet_seen  = 1'b0;
            end
        end
        else if (b == CH_SPACE)
        begin
            if (!octet_seen || octet_over || dot_count != DOTS_FULL)
                line_phase = PH_SKIP;
            else
            begin
                line_phase       = PH_NAME;
                octet_seen       = 1'b0;
                label_open_empty = 1'b1;
                label_fault      = 1'b0;
            end
        end
        else
            line_phase = PH_SKIP;
    endtask

    function automatic hlp_result_t make_word(input logic [1:0] k, input logic [7:0] nb,
                                              input logic [31:0] ip, input logic done);
        hlp_result_t r;
        r.kind       = k;
        r.name_byte  = nb;
        r.ip_address = ip;
        r.text_done  = done;
        r.run_last   = 1'b0;
        return r;
    endfunction

    // Work out the result words one accepted text byte causes
    task automatic parse_text_byte(input hlp_char_t w);
        hlp_result_t outs[2];
        int          n;
        logic [7:0]  b;
        logic [7:0]  c;
        logic        eot;
        logic        eol;
        logic        close_line;
        logic        record_good;
        n          = 0;
        b          = w.text_byte;
        eot        = w.end_of_text;
        eol        = (b == CH_LF) || (b == CH_CR);
        close_line = 1'b0;

        case (line_phase)
            PH_START:
            begin
                if (!eol)
                begin
                    clear_line_state();
                    line_phase = PH_ADDR;
                    feed_address(b);
                end
            end
            PH_ADDR:
            begin
                if (eol)
                    close_line = 1'b1;
                else
                    feed_address(b);
            end
            PH_NAME:
            begin
                if (eol)
                    close_line = 1'b1;
                else
                begin
                    c = b;
                    if (b == CH_DOT)
                    begin
                        if (label_open_empty)
                            label_fault = 1'b1;
                        label_open_empty = 1'b1;
                    end
                    else
                    begin
                        if (b >= CH_UP_A && b <= CH_UP_Z)
                            c = b + CASE_GAP;
                        label_open_empty = 1'b0;
                    end
                    // in the name, this flag means some name byte was seen
                    octet_seen = 1'b1;
                    outs[n] = make_word(KIND_NAME, c, 32'd0, 1'b0);
                    n++;
                end
            end
            default:
            begin
                if (eol)
                    close_line = 1'b1;
            end
        endcase

        if (!close_line && eot && line_phase != PH_START)
            close_line = 1'b1;

        if (close_line)
        begin
            record_good = (line_phase == PH_NAME) && !label_fault &&
                          !(label_open_empty && octet_seen);
            if (record_good)
                outs[n] = make_word(KIND_VALID, 8'd0, {high_octets, octet_acc}, eot);
            else
                outs[n] = make_word(KIND_INVALID, 8'd0, 32'd0, eot);
            n++;
            line_phase = PH_START;
            clear_line_state();
        end
        else if (eot)
        begin
            outs[n] = make_word(KIND_ENDED, 8'd0, 32'd0, 1'b1);
            n++;
        end

        if (eot)
        begin
            line_phase = PH_START;
            clear_line_state();
        end

        if (n > 0)
            outs[n - 1].run_last = 1'b1;
        for (int i = 0; i < n; i++)
            expected_parse_words.push_back(outs[i]);
    endtask

    // Compare one result word against the oldest outstanding one
    task automatic check_result_word(input hlp_result_t got);
        hlp_result_t want;
        if (expected_parse_words.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("%0t: unexpected result word kind %0d byte %02h ip %08h done %0b last %0b",
                         $realtime, got.kind, got.name_byte, got.ip_address, got.text_done,
                         got.run_last);
        end
        else
        begin
            want = expected_parse_words.pop_front();
            checked_words++;
            case (want.kind)
                KIND_NAME:    name_words++;
                KIND_VALID:   good_records++;
                KIND_INVALID: bad_records++;
                default:      bare_ends++;
            endcase
            if (got.kind !== want.kind || got.name_byte !== want.name_byte ||
                got.ip_address !== want.ip_address || got.text_done !== want.text_done ||
                got.run_last !== want.run_last)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                begin
                    $display("%0t: result word %0d mismatch", $realtime, checked_words);
                    $display("    want kind %0d byte %02h ip %08h done %0b last %0b",
                             want.kind, want.name_byte, want.ip_address, want.text_done,
                             want.run_last);
                    $display("    got  kind %0d byte %02h ip %08h done %0b last %0b",
                             got.kind, got.name_byte, got.ip_address, got.text_done,
                             got.run_last);
                end
            end
        end
    endtask

    // Drive text bytes, idling in random bursts outside the calm tail
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_valid <= 1'b0;
            char_word  <= '0;
            send_gap   <= 0;
        end
        else if (!char_valid || char_ready)
        begin
            if (send_gap != 0)
            begin
                char_valid <= 1'b0;
                send_gap   <= send_gap - 1;
            end
            else if (!calm_tail && $urandom_range(0, 9) == 0)
            begin
                char_valid <= 1'b0;
                send_gap   <= $urandom_range(0, 8);
            end
            else if (text_to_send.size() != 0)
            begin
                char_word  <= text_to_send.pop_front();
                char_valid <= 1'b1;
            end
            else
                char_valid <= 1'b0;
        end
    end

    // Predict on accepted bytes, check accepted results, stall the result side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            result_gap   <= 0;
            idle_count   <= 0;
            line_phase = PH_START;
            clear_line_state();
        end
        else
        begin
            if (char_valid && char_ready)
            begin
                parse_text_byte(char_word);
                sent_bytes++;
            end
            if (result_valid && result_ready)
                check_result_word(result_word);

            if ((char_valid && char_ready) || (result_valid && result_ready))
                idle_count <= 0;
            else
                idle_count <= idle_count + 1;

            if (result_gap != 0)
            begin
                result_ready <= 1'b0;
                result_gap   <= result_gap - 1;
            end
            else if (!calm_tail && $urandom_range(0, 7) == 0)
            begin
                result_ready <= 1'b0;
                result_gap   <= $urandom_range(0, 8);
            end
            else
                result_ready <= 1'b1;
        end
    end

    // Stop a hung run
    initial
    begin
        while (idle_count < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("FAILURE");
        $finish;
    end

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_bytes.push_back(s[i]);
    endtask

    // Move the first keep bytes of the line out, marking the last as end of text when eot_last is set
    task automatic send_line(input int keep, input bit eot_last);
        hlp_char_t w;
        for (int i = 0; i < keep; i++)
        begin
            w.text_byte   = line_bytes[i];
            w.end_of_text = eot_last && (i == keep - 1);
            text_to_send.push_back(w);
        end
        queued_bytes += keep;
        line_bytes.delete();
    endtask

    function automatic logic [7:0] name_char();
        logic [7:0] c;
        case ($urandom_range(0, 9))
            0, 1, 2: c = CH_UP_A + 8'($urandom_range(0, 25));
            3, 4, 5: c = CH_LOW_A + 8'($urandom_range(0, 25));
            6:       c = CH_ZERO + 8'($urandom_range(0, 9));
            7:       c = CH_HYPHEN;
            8:
            begin
                // neighbors of the uppercase and lowercase ranges
                case ($urandom_range(0, 3))
                    0:       c = CH_AT;
                    1:       c = CH_LBRACK;
                    2:       c = CH_TICK;
                    default: c = CH_LBRACE;
                endcase
            end
            default:
            begin
                c = 8'($urandom_range(0, 255));
                while (c == CH_LF || c == CH_CR || c == CH_DOT)
                    c = 8'($urandom_range(0, 255));
            end
        endcase
        return c;
    endfunction

    // Any byte that breaks an address: not a digit, dot, space or line end
    function automatic logic [7:0] stray_byte();
        logic [7:0] c;
        case ($urandom_range(0, 3))
            0:       c = CH_SLASH;
            1:       c = CH_COLON;
            default:
            begin
                c = 8'($urandom_range(0, 255));
                while ((c >= CH_ZERO && c <= CH_NINE) || c == CH_DOT || c == CH_SPACE ||
                       c == CH_LF || c == CH_CR)
                    c = 8'($urandom_range(0, 255));
            end
        endcase
        return c;
    endfunction

    task automatic put_octet();
        case ($urandom_range(0, 9))
            0:       put_text("0");
            1:       put_text("255");
            2:       put_text($sformatf("%03d", $urandom_range(0, 255)));
            default: put_text($sformatf("%0d", $urandom_range(0, 255)));
        endcase
    endtask

    // Dotted quad, or with one fault: wrong octet count, empty octet,
    // octet above 255, or a stray byte
    task automatic put_address(input bit faulty);
        int fault;
        int parts;
        int bad_at;
        fault = faulty ? $urandom_range(1, 4) : 0;
        if (fault == 1)
            parts = $urandom_range(0, 1) ? $urandom_range(1, 3) : 5;
        else
            parts = 4;
        bad_at = $urandom_range(0, parts - 1);
        for (int i = 0; i < parts; i++)
        begin
            if (i > 0)
                line_bytes.push_back(CH_DOT);
            if (i == bad_at && fault == 2)
                ;
            else if (i == bad_at && fault == 3)
                put_text($sformatf("%0d", $urandom_range(256, 99999)));
            else
                put_octet();
            if (i == bad_at && fault == 4)
                line_bytes.push_back(stray_byte());
        end
    endtask

    // Name of zero to three labels, with occasional empty labels
    task automatic put_name();
        int labels;
        int len;
        labels = $urandom_range(0, 3);
        if ($urandom_range(0, 11) == 0)
            line_bytes.push_back(CH_DOT);
        for (int l = 0; l < labels; l++)
        begin
            if (l > 0)
            begin
                line_bytes.push_back(CH_DOT);
                if ($urandom_range(0, 14) == 0)
                    line_bytes.push_back(CH_DOT);
            end
            len = $urandom_range(1, 6);
            for (int k = 0; k < len; k++)
                line_bytes.push_back(name_char());
        end
        if (labels > 0 && $urandom_range(0, 9) == 0)
            line_bytes.push_back(CH_DOT);
    endtask

    task automatic queue_random_line();
        int shape;
        int ending;
        int len;
        shape = $urandom_range(0, 19);
        if (shape < 13)
        begin
            put_address(1'b0);
            line_bytes.push_back(CH_SPACE);
            put_name();
        end
        else if (shape < 16)
        begin
            put_address(1'b1);
            line_bytes.push_back(CH_SPACE);
            put_name();
        end
        else if (shape == 16)
            put_address(1'b0);
        else if (shape == 17)
        begin
            line_bytes.push_back(CH_SPACE);
            put_name();
        end
        else
        begin
            len = $urandom_range(1, 12);
            for (int k = 0; k < len; k++)
                line_bytes.push_back(8'($urandom_range(0, 255)));
        end

        ending = $urandom_range(0, 19);
        len = line_bytes.size();
        if (ending < 13)
        begin
            case ($urandom_range(0, 4))
                0, 1: line_bytes.push_back(CH_LF);
                2:    line_bytes.push_back(CH_CR);
                3:
                begin
                    line_bytes.push_back(CH_CR);
                    line_bytes.push_back(CH_LF);
                end
                default:
                begin
                    line_bytes.push_back(CH_LF);
                    line_bytes.push_back(CH_LF);
                end
            endcase
            send_line(line_bytes.size(), 1'b0);
        end
        else if (ending < 16)
            send_line(len, 1'b1);
        else if (ending < 18)
            send_line($urandom_range(1, len), 1'b1);
        else
        begin
            // text ends on a blank line after the record
            line_bytes.push_back(CH_LF);
            send_line(line_bytes.size(), 1'b0);
            line_bytes.push_back(CH_LF);
            send_line(1, 1'b1);
        end
    endtask

    // Hold until every byte is accepted and every result word has come back
    task automatic wait_for_drain();
        @(negedge clk);
        while (text_to_send.size() != 0 || char_valid || expected_parse_words.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        // Directed text: leading line ends, extreme octets with case folding,
        // text end at line start, text end between lines, two words at text end
        line_bytes.push_back(CH_CR);
        line_bytes.push_back(CH_LF);
        send_line(2, 1'b0);
        put_text("255.1.0.9 A.z");
        line_bytes.push_back(CH_LF);
        send_line(line_bytes.size(), 1'b0);
        line_bytes.push_back(CH_HIGH);
        send_line(1, 1'b1);
        line_bytes.push_back(CH_LF);
        send_line(1, 1'b1);
        put_text("0.0.0.0 .x");
        send_line(line_bytes.size(), 1'b1);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // let the sender go quiet until every result is back
        wait_for_drain();

        queued_bytes = 0;
        while (queued_bytes < BUSY_BYTES)
            queue_random_line();
        while (text_to_send.size() != 0)
            @(negedge clk);

        // last stretch runs with no idling on either side
        calm_tail = 1'b1;
        while (queued_bytes < TOTAL_BYTES)
            queue_random_line();

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d text bytes; checked %0d result words: %0d name bytes,",
                 sent_bytes, checked_words, name_words);
        $display("%0d good records, %0d bad records, %0d bare text ends; %0d mismatches",
                 good_records, bad_records, bare_ends, mismatch_count);
        if (mismatch_count == 0 && expected_parse_words.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
